/* design/decimal_digit_arithmetic_unit_assert.svh */
// Assertion macros for the BCD arithmetic unit.
// Included by modules that check their own control sequencing.
`ifndef DECIMAL_DIGIT_ARITHMETIC_UNIT_ASSERT_SVH
`define DECIMAL_DIGIT_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddau assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddau assertion failed");

`endif

/* design/ddau_pkg.sv */
// Shared types and constants of the BCD arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package ddau_pkg;

  localparam int DIGITS = 16;
  localparam int DW     = 4 * DIGITS;
  localparam int CntW   = $clog2(DIGITS);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_UNDER = 2'd1,
    STS_DIVZ  = 2'd2,
    STS_BAD   = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic dstep;
    logic mend;
    logic sub;
    logic dshift;
    logic dtry;
    logic publish;
  } cmd_t;

  typedef struct packed {
    op_e     in_op;
    status_e in_status;
    logic    try_ok;
  } sts_t;

endpackage

/* design/decimal_digit_arithmetic_unit.sv */
// Top level of the BCD arithmetic unit: sequencer plus datapath.
// Depends on ddau_pkg, ddau_ctrl and ddau_datapath.
`timescale 1ns / 1ps
//
// Usage: a request carries op, a_digits and b_digits (packed BCD, low digit in
// the low nibble; nibbles at or above DIGITS are ignored). It is taken when
// in_valid_i is high and in_stall_o is low. One result per request comes out on
// result_low_o, result_high_o, order_o and status_o, taken when out_valid_o is
// high and out_stall_i is low. One request is worked at a time.
// Work per op, with DIGITS = D: add steps one digit per cycle through the
//   digit MAC, subtract makes one pass of the word BCD subtractor, multiply
//   runs D rows of D digit steps, each ended by a row close, divide does a
//   digit shift plus up to ten compare-subtract tries on the shared word
//   subtractor for each digit, and compare or error go straight to the result.
// The result sits in an output register, so a new request is taken as soon as
// the previous result is parked there, even while the receiver stalls; a stall
// only holds the finished result and then the next one in its final state.
// Reset clears the sequencer and the output valid flag; data registers are not
// reset.
module decimal_digit_arithmetic_unit import ddau_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        op_i,
  input  logic [63:0]       a_digits_i,
  input  logic [63:0]       b_digits_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       result_low_o,
  output logic [63:0]       result_high_o,
  output logic signed [1:0] order_o,
  output logic [1:0]        status_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: walks digits and rows, owns both handshakes
  ddau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: operand shifters, digit MAC, word subtractor, result register
  ddau_datapath u_dp (
    .clk_i        (clk_i),
    .op_i         (op_i),
    .a_digits_i   (a_digits_i),
    .b_digits_i   (b_digits_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .result_low_o (result_low_o),
    .result_high_o(result_high_o),
    .order_o      (order_o),
    .status_o     (status_o)
  );

endmodule

/* design/ddau_datapath.sv */
// Datapath of the BCD arithmetic unit: operand registers, digit MAC, word subtractor.
// Depends on ddau_pkg.
`timescale 1ns / 1ps

module ddau_datapath import ddau_pkg::*; (
  input  logic               clk_i,
  input  logic [2:0]         op_i,
  input  logic [63:0]        a_digits_i,
  input  logic [63:0]        b_digits_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic [63:0]        result_low_o,
  output logic [63:0]        result_high_o,
  output logic signed [1:0]  order_o,
  output logic [1:0]         status_o
);

  localparam int RW = DW + 4;

  function automatic logic [RW:0] bcd_sub(input logic [RW-1:0] x, input logic [RW-1:0] y);
    logic [RW:0]   d;
    logic [RW:0]   bw;
    logic [RW-1:0] f;
    d  = {1'b0, x} - {1'b0, y};
    bw = {d[RW], x ^ y ^ d[RW-1:0]};
    for (int k = 0; k < DIGITS + 1; k++) begin
      f[4*k +: 4] = bw[4*k+4] ? (d[4*k +: 4] - 4'd6) : d[4*k +: 4];
    end
    return {d[RW], f};
  endfunction

  logic [DW-1:0] a_q, b_q, p_q, lo_q, q_q;
  logic [RW-1:0] rem_q;
  logic [3:0]    c_q, qd_q;
  op_e           op_q;
  status_e       status_q;
  logic signed [1:0] ord_q;
  logic [63:0]   res_lo_q, res_hi_q;
  logic signed [1:0] res_ord_q;
  logic [1:0]    res_sts_q;

  // Input checks
  logic [DW-1:0] a_in, b_in;
  logic          bad_in, bzero_in;
  logic signed [1:0] ord_in;
  status_e       sts_in;
  op_e           op_in;

  assign a_in  = a_digits_i[DW-1:0];
  assign b_in  = b_digits_i[DW-1:0];
  assign op_in = op_e'(op_i);

  always_comb begin
    bad_in = 1'b0;
    for (int k = 0; k < DIGITS; k++) begin
      if (a_in[4*k +: 4] > 4'd9 || b_in[4*k +: 4] > 4'd9) bad_in = 1'b1;
    end
  end

  assign bzero_in = (b_in == '0);
  assign ord_in   = (a_in > b_in) ? 2'sb01 : ((a_in < b_in) ? 2'sb11 : 2'sb00);

  always_comb begin
    if (bad_in) sts_in = STS_BAD;
    else if (op_in == OP_SUB && ord_in == 2'sb11) sts_in = STS_UNDER;
    else if (op_in == OP_DIV && bzero_in) sts_in = STS_DIVZ;
    else sts_in = STS_OK;
  end

  // Digit multiply-accumulate: p + a*m + carry, split into digit and carry
  logic [3:0]  mul_m, dig, cy;
  logic [7:0]  prod, t;
  logic [18:0] recip;

  assign mul_m = (op_q == OP_ADD) ? 4'd1 : b_q[3:0];
  assign prod  = {4'd0, a_q[3:0]} * {4'd0, mul_m};
  assign t     = {4'd0, p_q[3:0]} + prod + {4'd0, c_q};
  assign recip = {11'd0, t} * 19'd205;
  assign cy    = recip[14:11];
  assign dig   = 4'(t - ({4'd0, cy} * 8'd10));

  // Shared word subtractor
  logic [RW-1:0] sx, sy, sdiff;
  logic          sbrw;
  assign sx = cmd_i.sub ? {4'd0, a_q} : rem_q;
  assign sy = {4'd0, b_q};
  assign {sbrw, sdiff} = bcd_sub(sx, sy);

  logic try_ok;
  assign try_ok = !sbrw && (qd_q != 4'd9);

  assign sts_o = '{in_op: op_in, in_status: sts_in, try_ok: try_ok};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q      <= a_in;
      b_q      <= b_in;
      p_q      <= (op_in == OP_ADD) ? b_in : '0;
      lo_q     <= '0;
      q_q      <= '0;
      rem_q    <= '0;
      c_q      <= '0;
      qd_q     <= '0;
      op_q     <= op_in;
      status_q <= sts_in;
      ord_q    <= ord_in;
    end
    if (cmd_i.dstep) begin
      p_q <= {dig, p_q[DW-1:4]};
      a_q <= {a_q[3:0], a_q[DW-1:4]};
      c_q <= cy;
    end
    if (cmd_i.mend) begin
      lo_q <= {p_q[3:0], lo_q[DW-1:4]};
      p_q  <= {c_q, p_q[DW-1:4]};
      c_q  <= '0;
      b_q  <= {b_q[3:0], b_q[DW-1:4]};
    end
    if (cmd_i.sub) begin
      p_q <= sdiff[DW-1:0];
    end
    if (cmd_i.dshift) begin
      rem_q <= {rem_q[DW-1:0], a_q[DW-1:DW-4]};
      a_q   <= {a_q[DW-5:0], 4'd0};
      qd_q  <= '0;
    end
    if (cmd_i.dtry) begin
      if (try_ok) begin
        rem_q <= sdiff;
        qd_q  <= qd_q + 4'd1;
      end else begin
        q_q <= {q_q[DW-5:0], qd_q};
      end
    end
    if (cmd_i.publish) begin
      res_ord_q <= ord_q;
      res_sts_q <= status_q;
      if (status_q == STS_OK) begin
        case (op_q)
          OP_ADD: begin
            res_lo_q <= 64'(p_q);
            res_hi_q <= 64'(c_q);
          end
          OP_SUB: begin
            res_lo_q <= 64'(p_q);
            res_hi_q <= '0;
          end
          OP_MUL: begin
            res_lo_q <= 64'(lo_q);
            res_hi_q <= 64'(p_q);
          end
          OP_DIV: begin
            res_lo_q <= 64'(q_q);
            res_hi_q <= '0;
          end
          default: begin
            res_lo_q <= '0;
            res_hi_q <= '0;
          end
        endcase
      end else begin
        res_lo_q <= '0;
        res_hi_q <= '0;
      end
    end
  end

  assign result_low_o  = res_lo_q;
  assign result_high_o = res_hi_q;
  assign order_o       = res_ord_q;
  assign status_o      = res_sts_q;

endmodule

/* design/ddau_ctrl.sv */
// Sequencer of the BCD arithmetic unit: digit and row counters, handshakes.
// Depends on ddau_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "decimal_digit_arithmetic_unit_assert.svh"

module ddau_ctrl import ddau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_MUL_DIG, S_MUL_END, S_SUB, S_DIV_SHIFT, S_DIV_TRY, S_FIN
  } state_e;

  localparam logic [CntW-1:0] Last = CntW'(DIGITS - 1);

  state_e          state_q;
  logic [CntW-1:0] cnt_q, row_q;
  logic            out_valid_q;
  logic            slot_free;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.dstep   = (state_q == S_ADD) || (state_q == S_MUL_DIG);
    cmd_o.mend    = (state_q == S_MUL_END);
    cmd_o.sub     = (state_q == S_SUB);
    cmd_o.dshift  = (state_q == S_DIV_SHIFT);
    cmd_o.dtry    = (state_q == S_DIV_TRY);
    cmd_o.publish = (state_q == S_FIN) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          row_q <= '0;
          if (in_valid_i) begin
            if (sts_i.in_status != STS_OK) begin
              state_q <= S_FIN;
            end else begin
              case (sts_i.in_op)
                OP_ADD:  state_q <= S_ADD;
                OP_SUB:  state_q <= S_SUB;
                OP_MUL:  state_q <= S_MUL_DIG;
                OP_DIV:  state_q <= S_DIV_SHIFT;
                default: state_q <= S_FIN;
              endcase
            end
          end
        end
        S_ADD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == Last) state_q <= S_FIN;
        end
        S_MUL_DIG: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == Last) state_q <= S_MUL_END;
        end
        S_MUL_END: begin
          row_q <= row_q + 1'b1;
          state_q <= (row_q == Last) ? S_FIN : S_MUL_DIG;
        end
        S_SUB: state_q <= S_FIN;
        S_DIV_SHIFT: state_q <= S_DIV_TRY;
        S_DIV_TRY: begin
          if (!sts_i.try_ok) begin
            cnt_q <= cnt_q + 1'b1;
            state_q <= (cnt_q == Last) ? S_FIN : S_DIV_SHIFT;
          end
        end
        S_FIN: begin
          if (slot_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `DDAU_ASSERT_IMP(a_pub_free, clk_i, rst_ni, cmd_o.publish, slot_free)
  `DDAU_ASSERT_NXT(a_mul_done, clk_i, rst_ni, state_q == S_MUL_END && row_q == Last, state_q == S_FIN)
  `DDAU_ASSERT_NXT(a_bad_fin, clk_i, rst_ni, cmd_o.load && sts_i.in_status != STS_OK, state_q == S_FIN)
  `DDAU_ASSERT_NXT(a_pub_valid, clk_i, rst_ni, cmd_o.publish, out_valid_q)

endmodule

/* dv/decimal_digit_arithmetic_unit_checker.sv */
// Checker for the BCD arithmetic unit: predicts each result and compares it.
// Depends on ddau_pkg; watches the request and result channels of the top level.
`timescale 1ns / 1ps

module decimal_digit_arithmetic_unit_checker import ddau_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [2:0]        op_i,
  input  logic [63:0]       a_digits_i,
  input  logic [63:0]       b_digits_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [63:0]       result_low_i,
  input  logic [63:0]       result_high_i,
  input  logic signed [1:0] order_i,
  input  logic [1:0]        status_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [63:0]       lo;
    logic [63:0]       hi;
    logic signed [1:0] ord;
    status_e           sts;
  } bcd_result_t;

  typedef logic [3:0] digit_t;
  typedef digit_t wide_t [0:2*DIGITS+1];

  bcd_result_t result_q[$];

  function automatic int compare_digits(wide_t x, wide_t y, int n);
    for (int i = n - 1; i >= 0; i--) begin
      if (x[i] > y[i]) return 1;
      if (x[i] < y[i]) return -1;
    end
    return 0;
  endfunction

  function automatic wide_t minus_digits(wide_t x, wide_t y, int n);
    int borrow;
    int t;
    borrow = 0;
    for (int i = 0; i < n; i++) begin
      t = y[i] + borrow;
      if (x[i] >= t) begin
        x[i] = x[i] - t;
        borrow = 0;
      end else begin
        x[i] = x[i] + 10 - t;
        borrow = 1;
      end
    end
    return x;
  endfunction

  function automatic bcd_result_t compute_bcd(logic [2:0] op, logic [63:0] av,
                                              logic [63:0] bv);
    wide_t a, b, r, rem;
    int col [0:2*DIGITS+1];
    bcd_result_t res;
    logic bad;
    logic nz;
    int carry;
    int s;
    int ordv;
    foreach (a[i]) begin
      a[i] = 0; b[i] = 0; r[i] = 0; rem[i] = 0; col[i] = 0;
    end
    bad = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      a[i] = av[4*i +: 4];
      b[i] = bv[4*i +: 4];
      if (a[i] > 9 || b[i] > 9) bad = 1'b1;
    end
    ordv = compare_digits(a, b, DIGITS);
    res.lo = '0;
    res.hi = '0;
    res.ord = 2'(ordv);
    res.sts = STS_OK;
    if (bad) begin
      res.sts = STS_BAD;
    end else if (op == OP_ADD) begin
      carry = 0;
      for (int i = 0; i < DIGITS; i++) begin
        s = a[i] + b[i] + carry;
        res.lo[4*i +: 4] = 4'(s % 10);
        carry = s / 10;
      end
      res.hi = 64'(carry);
    end else if (op == OP_SUB) begin
      if (ordv < 0) begin
        res.sts = STS_UNDER;
      end else begin
        r = minus_digits(a, b, DIGITS);
        for (int i = 0; i < DIGITS; i++) res.lo[4*i +: 4] = r[i];
      end
    end else if (op == OP_MUL) begin
      for (int i = 0; i < DIGITS; i++)
        for (int j = 0; j < DIGITS; j++) col[i+j] += a[i] * b[j];
      for (int i = 0; i < 2 * DIGITS; i++) begin
        col[i+1] += col[i] / 10;
        col[i] = col[i] % 10;
      end
      for (int i = 0; i < DIGITS; i++) begin
        res.lo[4*i +: 4] = 4'(col[i]);
        res.hi[4*i +: 4] = 4'(col[i+DIGITS]);
      end
    end else if (op == OP_DIV) begin
      nz = 1'b0;
      for (int i = 0; i < DIGITS; i++) if (b[i] != 0) nz = 1'b1;
      if (!nz) begin
        res.sts = STS_DIVZ;
      end else begin
        for (int i = DIGITS - 1; i >= 0; i--) begin
          for (int k = DIGITS; k > 0; k--) rem[k] = rem[k-1];
          rem[0] = a[i];
          while (compare_digits(rem, b, DIGITS + 1) >= 0 && r[i] < 9) begin
            rem = minus_digits(rem, b, DIGITS + 1);
            r[i]++;
          end
        end
        for (int i = 0; i < DIGITS; i++) res.lo[4*i +: 4] = r[i];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
  end

  assign pending_o = result_q.size();

  always @(posedge clk_i) begin
    bcd_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        result_q.push_back(compute_bcd(op_i, a_digits_i, b_digits_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", result_low_i, '0);
        end else begin
          want = result_q.pop_front();
          if (result_low_i !== want.lo) report_mismatch("result_low", result_low_i, want.lo);
          if (result_high_i !== want.hi)
            report_mismatch("result_high", result_high_i, want.hi);
          if (order_i !== want.ord) report_mismatch("order", 64'(order_i), 64'(want.ord));
          if (status_i !== want.sts) report_mismatch("status", 64'(status_i), 64'(want.sts));
        end
      end
    end
  end

endmodule

/* dv/decimal_digit_arithmetic_unit_tb.sv */
// Testbench top for the BCD arithmetic unit: clock, reset, stimulus, verdict.
// Depends on ddau_pkg, the block and decimal_digit_arithmetic_unit_checker.
`timescale 1ns / 1ps

module decimal_digit_arithmetic_unit_tb import ddau_pkg::*;;

  localparam int StallLimit = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [2:0]        op_i = OP_ADD;
  logic [63:0]       a_digits_i = '0;
  logic [63:0]       b_digits_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [63:0]       result_low_o;
  logic [63:0]       result_high_o;
  logic signed [1:0] order_o;
  logic [1:0]        status_o;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;
  logic              hold_off = 1'b0;

  always #4 clk_i = ~clk_i;

  decimal_digit_arithmetic_unit u_top (.*);

  decimal_digit_arithmetic_unit_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .op_i, .a_digits_i,
    .b_digits_i, .out_valid_i(out_valid_o), .out_stall_i, .result_low_i(result_low_o),
    .result_high_i(result_high_o), .order_i(order_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Random decimal operand with n significant digits.
  function automatic logic [63:0] rand_bcd(int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[4*i +: 4] = 4'($urandom_range(9));
    return v;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    op_i <= op;
    a_digits_i <= a;
    b_digits_i <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and idle for some cycles.
  task automatic idle_gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Receiver: random stall pattern, plus a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(3) == 0);
  end

  // Watchdog: count cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] a, b;
    logic [2:0] op;
    int burst;
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every op, invalid digits, underflow, divide by zero.
    send_request(OP_ADD, 64'h9999_9999_9999_9999, 64'h9999_9999_9999_9999);
    send_request(OP_ADD, '0, '0);
    send_request(OP_SUB, 64'h5, 64'h7);
    send_request(OP_SUB, 64'h1000_0000_0000_0000, 64'h1);
    send_request(OP_SUB, 64'h42, 64'h42);
    send_request(OP_MUL, 64'h9999_9999_9999_9999, 64'h9999_9999_9999_9999);
    send_request(OP_MUL, 64'h0, 64'h1234);
    send_request(OP_DIV, 64'h9999_9999_9999_9999, 64'h1);
    send_request(OP_DIV, 64'h1234, 64'h0);
    send_request(OP_DIV, 64'h7, 64'h9999_9999_9999_9999);
    send_request(OP_DIV, 64'h9999_9999_9999_9999, 64'h3);
    send_request(OP_CMP, 64'h123, 64'h124);
    send_request(OP_CMP, 64'h124, 64'h123);
    send_request(3'd5, 64'h1, 64'h1);
    send_request(3'd6, 64'h9, 64'h0);
    send_request(3'd7, 64'h0, 64'h9);
    send_request(OP_ADD, 64'hF000_0000_0000_0000, 64'h1);
    send_request(OP_MUL, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_CMP, 64'hA, 64'hB);
    send_request(OP_DIV, 64'hC, 64'h0);

    // Long hold-off on the receiver while requests keep coming.
    hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      for (int k = 0; k < 6; k++) send_request(OP_SUB, rand_bcd(16), rand_bcd(4));
    join
    // Pause until every expected result is back.
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    // Random bursts; keep the second multiply and divide operand mostly short.
    n = 0;
    while (n < 450) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) begin
        op = 3'($urandom_range(7));
        if ($urandom_range(19) == 0) begin
          a = {$urandom, $urandom};
          b = {$urandom, $urandom};
        end else if (op == OP_MUL || op == OP_DIV) begin
          a = rand_bcd($urandom_range(16));
          b = rand_bcd($urandom_range(0, 5) == 0 ? 16 : $urandom_range(4));
        end else begin
          a = rand_bcd($urandom_range(16));
          b = rand_bcd($urandom_range(16));
        end
        send_request(op, a, b);
        n++;
      end
      if ($urandom_range(2) != 0) idle_gap($urandom_range(1, 30));
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ddau_pkg.sv
design/ddau_datapath.sv
design/ddau_ctrl.sv
design/decimal_digit_arithmetic_unit.sv
dv/decimal_digit_arithmetic_unit_checker.sv
dv/decimal_digit_arithmetic_unit_tb.sv
